[design/uts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uts_pkg
// Shared types, constants and character helpers of the UTF-8 token scanner.
// ----------------------------------------------------------------------------
package uts_pkg;

    localparam int OFFSET_BITS   = 24;
    localparam int POSITION_BITS = 16;
    localparam int CP_BITS       = 26;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 8;

    localparam logic [OFFSET_BITS-1:0]   OFF_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    localparam logic [CFG_IDX_BITS-1:0] REG_SKIP_WS  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PER_CHAR = 2'd1;

    localparam logic [CP_BITS-1:0] CH_TAB   = 26'h09;
    localparam logic [CP_BITS-1:0] CH_LF    = 26'h0A;
    localparam logic [CP_BITS-1:0] CH_CR    = 26'h0D;
    localparam logic [CP_BITS-1:0] CH_SPACE = 26'h20;

    typedef enum logic [2:0] {
        K_WS    = 3'd0,
        K_DIGIT = 3'd1,
        K_ALPHA = 3'd2,
        K_OTHER = 3'd3,
        K_END   = 3'd4,
        K_BAD   = 3'd5,
        K_NONE  = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        SK_UNKNOWN = 2'd0,
        SK_SPACE   = 2'd1,
        SK_TAB     = 2'd2,
        SK_NEWLINE = 2'd3
    } space_t;

    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_CR   = 2'd1,
        PEND_LF   = 2'd2
    } pend_t;

    typedef struct packed {
        logic [2:0]               token_kind;
        logic [1:0]               space_kind;
        logic [CP_BITS-1:0]       code_point;
        logic [OFFSET_BITS-1:0]   start_offset;
        logic [OFFSET_BITS-1:0]   byte_length;
        logic [POSITION_BITS-1:0] token_row;
        logic [POSITION_BITS-1:0] start_column;
        logic                     after_whitespace;
        logic                     after_newline;
        logic                     run_end;
    } tok_t;

    typedef struct packed {
        logic [CP_BITS-1:0]       acc;
        logic [2:0]               cont_left;
        kind_t                    run_kind;
        logic [CP_BITS-1:0]       run_first;
        logic                     run_many;
        logic [OFFSET_BITS-1:0]   run_start;
        logic [OFFSET_BITS-1:0]   pos;
        logic [POSITION_BITS-1:0] row;
        logic [POSITION_BITS-1:0] col;
        logic [POSITION_BITS-1:0] run_row;
        logic [POSITION_BITS-1:0] run_col;
        logic [1:0]               passed;
        pend_t                    pend;
        logic                     stopped;
        logic [OFFSET_BITS-1:0]   char_start;
    } st_t;

    function automatic kind_t class_of(input logic [CP_BITS-1:0] c);
        kind_t k;
        if (c == CH_SPACE || (c >= 26'h09 && c <= 26'h0D))
            k = K_WS;
        else if (c >= 26'h30 && c <= 26'h39)
            k = K_DIGIT;
        else if ((c >= 26'h41 && c <= 26'h5A) || (c >= 26'h61 && c <= 26'h7A)
                 || c >= 26'h80)
            k = K_ALPHA;
        else
            k = K_OTHER;
        return k;
    endfunction

    function automatic space_t space_of(input logic [CP_BITS-1:0] c);
        space_t s;
        if (c == CH_CR || c == CH_LF)
            s = SK_NEWLINE;
        else if (c == CH_TAB)
            s = SK_TAB;
        else if (c == CH_SPACE)
            s = SK_SPACE;
        else
            s = SK_UNKNOWN;
        return s;
    endfunction

    function automatic tok_t mk_tok(
        input kind_t                    kind,
        input space_t                   sk,
        input logic [CP_BITS-1:0]       cp,
        input logic [OFFSET_BITS-1:0]   start,
        input logic [OFFSET_BITS-1:0]   stop,
        input logic [POSITION_BITS-1:0] row,
        input logic [POSITION_BITS-1:0] col,
        input logic [1:0]               flags
    );
        tok_t t;
        t.token_kind       = kind;
        t.space_kind       = sk;
        t.code_point       = cp;
        t.start_offset     = start;
        t.byte_length      = (stop > start) ? stop - start : '0;
        t.token_row        = row;
        t.start_column     = col;
        t.after_whitespace = flags[0];
        t.after_newline    = flags[1];
        t.run_end          = 1'b0;
        return t;
    endfunction

endpackage

[design/uts_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uts interfaces
// Byte input, token output and configuration write channels.
// ----------------------------------------------------------------------------
interface uts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;
    modport source (output valid, text_byte, final_byte, input ready);
    modport sink   (input valid, text_byte, final_byte, output ready);
endinterface

interface uts_tok_if;
    import uts_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [2:0]               token_kind;
    logic [1:0]               space_kind;
    logic [CP_BITS-1:0]       code_point;
    logic [OFFSET_BITS-1:0]   start_offset;
    logic [OFFSET_BITS-1:0]   byte_length;
    logic [POSITION_BITS-1:0] token_row;
    logic [POSITION_BITS-1:0] start_column;
    logic                     after_whitespace;
    logic                     after_newline;
    logic                     run_end;
    modport source (output valid, token_kind, space_kind, code_point, start_offset,
                    byte_length, token_row, start_column, after_whitespace,
                    after_newline, run_end, input ready);
    modport sink   (input valid, token_kind, space_kind, code_point, start_offset,
                    byte_length, token_row, start_column, after_whitespace,
                    after_newline, run_end, output ready);
endinterface

interface uts_cfg_if;
    import uts_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/utf8_token_scanner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_token_scanner
// Decodes a UTF-8 byte stream and groups code points into tokens.
// Tokens are registered in the result buffer before they leave.
// Throughput: one byte per cycle while buffer space allows; up to three tokens
// per byte queue in a four-entry result buffer drained one token per cycle while the sink is ready.
// Reset: asynchronous, clears scanner state and registers and empties the buffer.
// ----------------------------------------------------------------------------
module utf8_token_scanner (
    input  logic clk,
    input  logic rst_n,
    uts_cfg_if.sink    cfg,
    uts_byte_if.sink   text,
    uts_tok_if.source  token
);
    import uts_pkg::*;

    localparam st_t ST_INIT = '{
        acc:        '0,
        cont_left:  '0,
        run_kind:   K_NONE,
        run_first:  '0,
        run_many:   1'b0,
        run_start:  '0,
        pos:        '0,
        row:        POSITION_BITS'(1),
        col:        POSITION_BITS'(1),
        run_row:    POSITION_BITS'(1),
        run_col:    POSITION_BITS'(1),
        passed:     2'b00,
        pend:       PEND_NONE,
        stopped:    1'b0,
        char_start: '0
    };

    st_t        st_reg, st_next;
    logic       skip_reg, perc_reg;
    tok_t       fifo_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] cnt_reg;
    tok_t       slot [3];
    logic [1:0] n_res;
    logic       take, pop;

    assign cfg.ready  = 1'b1;
    assign pop        = token.valid && token.ready;
    assign text.ready = (cnt_reg <= 3'd1) || (cnt_reg == 3'd2 && pop);
    assign take       = text.valid && text.ready;

    function automatic void flush(inout st_t s, inout tok_t q [3], inout logic [1:0] n,
                                  input logic [OFFSET_BITS-1:0] stop);
        if (s.run_kind != K_NONE)
        begin
            q[n] = mk_tok(s.run_kind, (s.run_kind == K_WS) ? SK_NEWLINE : SK_UNKNOWN,
                          s.run_many ? '0 : s.run_first, s.run_start, stop,
                          s.run_row, s.run_col, s.passed);
            n = n + 2'd1;
            s.passed   = 2'b00;
            s.run_kind = K_NONE;
        end
    endfunction

    function automatic void finish(inout st_t s, inout tok_t q [3], inout logic [1:0] n,
                                   input kind_t kind, input logic [OFFSET_BITS-1:0] stop,
                                   input logic [OFFSET_BITS-1:0] at);
        flush(s, q, n, stop);
        q[n] = mk_tok(kind, SK_UNKNOWN, '0, at, at, s.row, s.col, s.passed);
        n = n + 2'd1;
        s.passed    = 2'b00;
        s.pend      = PEND_NONE;
        s.cont_left = '0;
        s.stopped   = 1'b1;
    endfunction

    function automatic void start_run(inout st_t s, input kind_t kind,
                                      input logic [CP_BITS-1:0] c);
        s.run_kind  = kind;
        s.run_first = c;
        s.run_many  = 1'b0;
        s.run_start = s.char_start;
        s.run_row   = s.row;
        s.run_col   = s.col;
    endfunction

    function automatic void take_char(inout st_t s, inout tok_t q [3], inout logic [1:0] n,
                                      input logic [CP_BITS-1:0] c,
                                      input logic [OFFSET_BITS-1:0] nxt,
                                      input logic skip, input logic perc);
        kind_t ty;
        logic  nl;
        ty = class_of(c);
        nl = (c == CH_CR) || (c == CH_LF);
        if (s.run_kind != K_NONE && s.run_kind != K_WS && (perc || ty != s.run_kind))
            flush(s, q, n, s.char_start);
        if (perc)
        begin
            s.passed = 2'b00;
            if (nl)
            begin
                start_run(s, K_WS, c);
                s.pend = (c == CH_CR) ? PEND_CR : PEND_LF;
            end
            else
            begin
                q[n] = mk_tok(ty, (ty == K_WS) ? space_of(c) : SK_UNKNOWN, c,
                              s.char_start, nxt, s.row, s.col, 2'b00);
                n = n + 2'd1;
            end
        end
        else if (s.run_kind == ty)
        begin
            s.run_many = 1'b1;
        end
        else if (ty == K_WS)
        begin
            s.passed = s.passed | (nl ? 2'b11 : 2'b01);
            if (nl)
                s.pend = (c == CH_CR) ? PEND_CR : PEND_LF;
            if (!skip)
            begin
                if (nl)
                    start_run(s, K_WS, c);
                else
                begin
                    q[n] = mk_tok(K_WS, space_of(c), c, s.char_start, nxt,
                                  s.row, s.col, s.passed);
                    n = n + 2'd1;
                    s.passed = 2'b00;
                end
            end
        end
        else if (ty == K_OTHER)
        begin
            q[n] = mk_tok(K_OTHER, SK_UNKNOWN, c, s.char_start, nxt, s.row, s.col, s.passed);
            n = n + 2'd1;
            s.passed = 2'b00;
        end
        else
        begin
            start_run(s, ty, c);
        end
        if (nl)
        begin
            s.row = (s.row == POS_MAX) ? s.row : s.row + 1'b1;
            s.col = POSITION_BITS'(1);
        end
        else
        begin
            s.col = (s.col == POS_MAX) ? s.col : s.col + 1'b1;
        end
    endfunction

    always_comb
    begin
        st_t                  s;
        tok_t                 q [3];
        logic [1:0]           n;
        logic [7:0]           b;
        logic                 fin, done, pair;
        logic [OFFSET_BITS-1:0] here, nxt;
        s    = st_reg;
        n    = 2'd0;
        q[0] = '0;
        q[1] = '0;
        q[2] = '0;
        b    = text.text_byte;
        fin  = text.final_byte;
        done = 1'b0;
        here = st_reg.pos;
        nxt  = (st_reg.pos == OFF_MAX) ? st_reg.pos : st_reg.pos + 1'b1;
        pair = 1'b0;
        if (take && !st_reg.stopped)
        begin
            s.pos = nxt;
            if (s.pend != PEND_NONE)
            begin
                pair = (s.pend == PEND_CR && b == 8'h0A) || (s.pend == PEND_LF && b == 8'h0D);
                s.pend = PEND_NONE;
                if (pair)
                begin
                    if (s.run_kind == K_WS)
                        flush(s, q, n, nxt);
                    if (fin)
                        finish(s, q, n, K_END, nxt, nxt);
                    done = 1'b1;
                end
                else if (s.run_kind == K_WS)
                    flush(s, q, n, here);
            end
            if (!done)
            begin
                if (s.cont_left == 3'd0)
                begin
                    s.char_start = here;
                    if (b == 8'h00)
                    begin
                        finish(s, q, n, K_END, here, here);
                        done = 1'b1;
                    end
                    else if (!b[7])
                        take_char(s, q, n, CP_BITS'(b), nxt, skip_reg, perc_reg);
                    else if ((b & 8'hE0) == 8'hC0)
                    begin
                        s.acc = CP_BITS'(b & 8'h1F);
                        s.cont_left = 3'd1;
                    end
                    else if ((b & 8'hF0) == 8'hE0)
                    begin
                        s.acc = CP_BITS'(b & 8'h0F);
                        s.cont_left = 3'd2;
                    end
                    else if ((b & 8'hF8) == 8'hF0)
                    begin
                        s.acc = CP_BITS'(b & 8'h07);
                        s.cont_left = 3'd3;
                    end
                    else if ((b & 8'hFC) == 8'hF8)
                    begin
                        s.acc = CP_BITS'(b & 8'h03);
                        s.cont_left = 3'd4;
                    end
                    else
                    begin
                        finish(s, q, n, K_BAD, here, here);
                        done = 1'b1;
                    end
                end
                else if ((b & 8'hC0) != 8'h80)
                begin
                    finish(s, q, n, K_BAD, s.char_start, here);
                    done = 1'b1;
                end
                else
                begin
                    s.acc = {s.acc[CP_BITS-7:0], b[5:0]};
                    s.cont_left = s.cont_left - 3'd1;
                    if (s.cont_left == 3'd0)
                    begin
                        if (s.acc == '0)
                        begin
                            finish(s, q, n, K_BAD, s.char_start, here);
                            done = 1'b1;
                        end
                        else
                            take_char(s, q, n, s.acc, nxt, skip_reg, perc_reg);
                    end
                end
                if (!done && fin)
                begin
                    if (s.cont_left != 3'd0)
                        finish(s, q, n, K_BAD, s.char_start, nxt);
                    else
                        finish(s, q, n, K_END, nxt, nxt);
                end
            end
            if (n != 2'd0)
                q[n - 2'd1].run_end = 1'b1;
        end
        st_next = s;
        slot    = q;
        n_res   = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg            <= ST_INIT;
            skip_reg          <= 1'b0;
            perc_reg          <= 1'b0;
            wr_ptr_reg        <= '0;
            rd_ptr_reg        <= '0;
            cnt_reg           <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_SKIP_WS:  skip_reg <= cfg.data[0];
                    REG_PER_CHAR: perc_reg <= cfg.data[0];
                    default: ;
                endcase
            end
            wr_ptr_reg <= wr_ptr_reg + n_res;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            cnt_reg <= cnt_reg + {1'b0, n_res} - {2'b00, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (2'(k) < n_res)
                fifo_reg[wr_ptr_reg + 2'(k)] <= slot[k];
        end
    end

    assign token.valid            = (cnt_reg != 3'd0);
    assign token.token_kind       = fifo_reg[rd_ptr_reg].token_kind;
    assign token.space_kind       = fifo_reg[rd_ptr_reg].space_kind;
    assign token.code_point       = fifo_reg[rd_ptr_reg].code_point;
    assign token.start_offset     = fifo_reg[rd_ptr_reg].start_offset;
    assign token.byte_length      = fifo_reg[rd_ptr_reg].byte_length;
    assign token.token_row        = fifo_reg[rd_ptr_reg].token_row;
    assign token.start_column     = fifo_reg[rd_ptr_reg].start_column;
    assign token.after_whitespace = fifo_reg[rd_ptr_reg].after_whitespace;
    assign token.after_newline    = fifo_reg[rd_ptr_reg].after_newline;
    assign token.run_end          = fifo_reg[rd_ptr_reg].run_end;

endmodule

[tb/sv/tb_utf8_token_scanner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_token_scanner
// Self-checking bench for the UTF-8 token scanner. A queue of text bytes feeds
// a bursty driver. A predictor works out the tokens due for every accepted
// byte. A monitor behind a stalling sink checks each token field by field.
// The skip and per-character settings change between phases of one text,
// and the text closes with one randomly chosen end case.
// ----------------------------------------------------------------------------
module tb_utf8_token_scanner;
    import uts_pkg::*;

    localparam int LIMIT = 200000;

    typedef struct {
        logic [7:0] b;
        logic       f;
    } text_xfer_t;

    logic clk;
    logic rst_n;

    uts_cfg_if  cfg ();
    uts_byte_if text ();
    uts_tok_if  token ();

    utf8_token_scanner dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .text  (text),
        .token (token)
    );

    text_xfer_t byte_q[$];
    tok_t       expected_tokens[$];

    int mismatches  = 0;
    int tokens_seen = 0;
    int bytes_sent  = 0;
    int cycles      = 0;
    int burst_left;
    int gap_left;

    // scanner state mirror
    logic                     skip_ws    = 1'b0;
    logic                     per_char   = 1'b0;
    logic [CP_BITS-1:0]       acc        = '0;
    logic [2:0]               cont_left  = '0;
    kind_t                    run_kind   = K_NONE;
    logic [CP_BITS-1:0]       run_first  = '0;
    logic                     run_many   = 1'b0;
    logic [OFFSET_BITS-1:0]   run_start  = '0;
    logic [OFFSET_BITS-1:0]   pos        = '0;
    logic [POSITION_BITS-1:0] row        = POSITION_BITS'(1);
    logic [POSITION_BITS-1:0] col        = POSITION_BITS'(1);
    logic [POSITION_BITS-1:0] run_row    = POSITION_BITS'(1);
    logic [POSITION_BITS-1:0] run_col    = POSITION_BITS'(1);
    logic [1:0]               passed     = 2'b00;
    logic [CP_BITS-1:0]       pend_nl    = '0;
    logic                     stopped    = 1'b0;
    logic [OFFSET_BITS-1:0]   char_start = '0;

    function automatic kind_t char_class(logic [CP_BITS-1:0] c);
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
            return K_WS;
        if (c >= 26'h30 && c <= 26'h39)
            return K_DIGIT;
        if ((c >= 26'h41 && c <= 26'h5A) || (c >= 26'h61 && c <= 26'h7A) || c >= 26'h80)
            return K_ALPHA;
        return K_OTHER;
    endfunction

    function automatic space_t blank_kind(logic [CP_BITS-1:0] c);
        if (c == CH_CR || c == CH_LF)
            return SK_NEWLINE;
        if (c == CH_TAB)
            return SK_TAB;
        if (c == CH_SPACE)
            return SK_SPACE;
        return SK_UNKNOWN;
    endfunction

    function automatic void push_token(kind_t k, space_t sk, logic [CP_BITS-1:0] cp,
                                       logic [OFFSET_BITS-1:0] start,
                                       logic [OFFSET_BITS-1:0] stop,
                                       logic [POSITION_BITS-1:0] r,
                                       logic [POSITION_BITS-1:0] c, logic [1:0] flags);
        tok_t t;
        t.token_kind       = k;
        t.space_kind       = sk;
        t.code_point       = cp;
        t.start_offset     = start;
        t.byte_length      = (stop > start) ? stop - start : '0;
        t.token_row        = r;
        t.start_column     = c;
        t.after_whitespace = flags[0];
        t.after_newline    = flags[1];
        t.run_end          = 1'b0;
        expected_tokens.push_back(t);
    endfunction

    function automatic void close_run(logic [OFFSET_BITS-1:0] stop);
        if (run_kind != K_NONE)
        begin
            push_token(run_kind, (run_kind == K_WS) ? SK_NEWLINE : SK_UNKNOWN,
                       run_many ? '0 : run_first, run_start, stop, run_row, run_col, passed);
            passed   = 2'b00;
            run_kind = K_NONE;
        end
    endfunction

    function automatic void end_text(kind_t k, logic [OFFSET_BITS-1:0] stop,
                                     logic [OFFSET_BITS-1:0] at);
        close_run(stop);
        push_token(k, SK_UNKNOWN, '0, at, at, row, col, passed);
        passed    = 2'b00;
        pend_nl   = '0;
        cont_left = '0;
        stopped   = 1'b1;
    endfunction

    function automatic void open_run(kind_t k, logic [CP_BITS-1:0] c);
        run_kind  = k;
        run_first = c;
        run_many  = 1'b0;
        run_start = char_start;
        run_row   = row;
        run_col   = col;
    endfunction

    function automatic void accept_char(logic [CP_BITS-1:0] c, logic [OFFSET_BITS-1:0] nxt);
        kind_t k;
        logic  nl;
        k  = char_class(c);
        nl = (c == CH_CR || c == CH_LF);
        if (run_kind != K_NONE && run_kind != K_WS && (per_char || k != run_kind))
            close_run(char_start);
        if (per_char)
        begin
            passed = 2'b00;
            if (nl)
            begin
                open_run(K_WS, c);
                pend_nl = c;
            end
            else
                push_token(k, (k == K_WS) ? blank_kind(c) : SK_UNKNOWN, c, char_start, nxt,
                           row, col, 2'b00);
        end
        else if (run_kind == k)
            run_many = 1'b1;
        else if (k == K_WS)
        begin
            passed |= nl ? 2'b11 : 2'b01;
            if (nl)
                pend_nl = c;
            if (!skip_ws)
            begin
                if (nl)
                    open_run(K_WS, c);
                else
                begin
                    push_token(K_WS, blank_kind(c), c, char_start, nxt, row, col, passed);
                    passed = 2'b00;
                end
            end
        end
        else if (k == K_OTHER)
        begin
            push_token(K_OTHER, SK_UNKNOWN, c, char_start, nxt, row, col, passed);
            passed = 2'b00;
        end
        else
            open_run(k, c);
        if (nl)
        begin
            row = (row == POS_MAX) ? row : row + 1'b1;
            col = POSITION_BITS'(1);
        end
        else
            col = (col == POS_MAX) ? col : col + 1'b1;
    endfunction

    function automatic void scan_byte(logic [7:0] b, logic fin);
        logic [OFFSET_BITS-1:0] here;
        logic [OFFSET_BITS-1:0] nxt;
        logic                   pair;
        logic                   done;
        int                     before_n;
        before_n = expected_tokens.size();
        done     = 1'b0;
        if (stopped)
            return;
        here = pos;
        nxt  = (pos == OFF_MAX) ? pos : pos + 1'b1;
        pos  = nxt;
        if (pend_nl != '0)
        begin
            pair = (pend_nl == CH_CR && b == CH_LF[7:0]) || (pend_nl == CH_LF && b == CH_CR[7:0]);
            pend_nl = '0;
            if (pair)
            begin
                if (run_kind == K_WS)
                    close_run(nxt);
                if (fin)
                    end_text(K_END, nxt, nxt);
                done = 1'b1;
            end
            else if (run_kind == K_WS)
                close_run(here);
        end
        if (!done)
        begin
            if (cont_left == 3'd0)
            begin
                char_start = here;
                if (b == 8'h00)
                begin
                    end_text(K_END, here, here);
                    done = 1'b1;
                end
                else if (b < 8'h80)
                    accept_char({18'd0, b}, nxt);
                else if ((b & 8'hE0) == 8'hC0)
                begin
                    acc = CP_BITS'(b & 8'h1F);
                    cont_left = 3'd1;
                end
                else if ((b & 8'hF0) == 8'hE0)
                begin
                    acc = CP_BITS'(b & 8'h0F);
                    cont_left = 3'd2;
                end
                else if ((b & 8'hF8) == 8'hF0)
                begin
                    acc = CP_BITS'(b & 8'h07);
                    cont_left = 3'd3;
                end
                else if ((b & 8'hFC) == 8'hF8)
                begin
                    acc = CP_BITS'(b & 8'h03);
                    cont_left = 3'd4;
                end
                else
                begin
                    end_text(K_BAD, here, here);
                    done = 1'b1;
                end
            end
            else if ((b & 8'hC0) != 8'h80)
            begin
                end_text(K_BAD, char_start, here);
                done = 1'b1;
            end
            else
            begin
                acc = {acc[CP_BITS-7:0], b[5:0]};
                cont_left = cont_left - 3'd1;
                if (cont_left == 3'd0)
                begin
                    if (acc == '0)
                    begin
                        end_text(K_BAD, char_start, here);
                        done = 1'b1;
                    end
                    else
                        accept_char(acc, nxt);
                end
            end
        end
        if (!done && fin)
        begin
            if (cont_left != 3'd0)
                end_text(K_BAD, char_start, nxt);
            else
                end_text(K_END, nxt, nxt);
        end
        if (expected_tokens.size() > before_n)
            expected_tokens[expected_tokens.size()-1].run_end = 1'b1;
    endfunction

    function automatic void queue_byte(logic [7:0] b, logic f);
        text_xfer_t x;
        x.b = b;
        x.f = f;
        byte_q.push_back(x);
    endfunction

    function automatic void queue_utf8(logic [CP_BITS-1:0] cp, int len);
        case (len)
            1: queue_byte(cp[7:0], 1'b0);
            2: queue_byte(8'hC0 | cp[10:6], 1'b0);
            3: queue_byte(8'hE0 | cp[15:12], 1'b0);
            4: queue_byte(8'hF0 | cp[20:18], 1'b0);
            default: queue_byte(8'hF8 | cp[25:24], 1'b0);
        endcase
        for (int i = len - 2; i >= 0; i--)
            queue_byte(8'h80 | 8'((cp >> (6 * i)) & 26'h3F), 1'b0);
    endfunction

    function automatic void queue_random_char();
        int                 sel;
        int                 len;
        logic [CP_BITS-1:0] cp;
        sel = $urandom_range(0, 15);
        case (sel)
            0, 1, 2: queue_byte(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
            3:       queue_byte(8'($urandom_range(8'h41, 8'h5A)), 1'b0);
            4, 5:    queue_byte(8'($urandom_range(8'h30, 8'h39)), 1'b0);
            6:       queue_byte(8'h20, 1'b0);
            7:       queue_byte(8'($urandom_range(8'h09, 8'h0D)), 1'b0);
            8:
            begin
                queue_byte(8'h0D, 1'b0);
                queue_byte(8'h0A, 1'b0);
            end
            9:
            begin
                queue_byte(8'h0A, 1'b0);
                queue_byte(8'h0D, 1'b0);
            end
            10, 11: queue_byte(8'($urandom_range(1, 8'h7F)), 1'b0);
            default:
            begin
                len = $urandom_range(2, 5);
                if (len == 5)
                    cp = CP_BITS'($urandom);
                else
                    cp = CP_BITS'({$urandom, $urandom}
                                  & ((64'h1 << (5 * len + 1)) - 64'h1));
                if (cp == '0)
                    cp = 26'h1;
                queue_utf8(cp, len);
            end
        endcase
    endfunction

    function automatic void queue_ending();
        queue_byte(8'h31, 1'b0);
        queue_byte(8'h32, 1'b0);
        case ($urandom_range(0, 7))
            0: queue_byte(8'h61, 1'b1);
            1: queue_byte(8'h00, 1'b1);
            2:
            begin
                queue_byte(8'hE2, 1'b0);
                queue_byte(8'h82, 1'b1);
            end
            3: queue_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b1);
            4: queue_byte(8'($urandom_range(8'hFC, 8'hFF)), 1'b1);
            5:
            begin
                queue_byte(8'hC3, 1'b0);
                queue_byte(8'h41, 1'b1);
            end
            6:
            begin
                queue_byte(8'hC0, 1'b0);
                queue_byte(8'h80, 1'b1);
            end
            default:
            begin
                queue_byte(8'h0D, 1'b0);
                queue_byte(8'h0A, 1'b1);
            end
        endcase
        for (int i = 0; i < 6; i++)
            queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endfunction

    task automatic wait_idle();
        while (byte_q.size() != 0 || text.valid || expected_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic value);
        logic [CFG_DATA_BITS-1:0] d;
        d = {7'($urandom_range(0, 127)), value};
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= d;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_SKIP_WS)
            skip_ws = d[0];
        else if (idx == REG_PER_CHAR)
            per_char = d[0];
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        logic [1:0] modes[5];
        modes = '{2'b01, 2'b10, 2'b11, 2'b00, 2'b01};
        rst_n      = 1'b0;
        cfg.valid  = 1'b0;
        cfg.index  = '0;
        cfg.data   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (modes[m])
        begin
            if (m == 0)
            begin
                queue_byte(8'h41, 1'b0);
                queue_byte(8'h39, 1'b0);
                queue_byte(8'h20, 1'b0);
                queue_byte(8'h09, 1'b0);
                queue_byte(8'h0D, 1'b0);
                queue_byte(8'h0A, 1'b0);
                queue_byte(8'h0A, 1'b0);
                queue_byte(8'h0D, 1'b0);
                queue_byte(8'h0B, 1'b0);
                queue_byte(8'h21, 1'b0);
                queue_byte(8'h7F, 1'b0);
                queue_utf8(26'hE9, 2);
                queue_utf8(26'h20AC, 3);
                queue_utf8(26'h1F600, 4);
                queue_utf8(26'h3FFFFFF, 5);
                queue_byte(8'h7A, 1'b0);
            end
            else
                for (int i = 0; i < 25; i++)
                    queue_random_char();
            wait_idle();
            write_reg(REG_SKIP_WS, modes[m][0]);
            write_reg(REG_PER_CHAR, modes[m][1]);
        end
        queue_ending();
        wait_idle();
        repeat (20) @(posedge clk);
        $display("Scanned %0d bytes into %0d tokens over four mode settings.",
                 bytes_sent, tokens_seen);
        $display("Mismatches: %0d, tokens still expected: %0d",
                 mismatches, expected_tokens.size());
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text.valid      <= 1'b0;
            text.text_byte  <= '0;
            text.final_byte <= 1'b0;
            burst_left      <= 0;
            gap_left        <= 0;
        end
        else
        begin
            if (text.valid && text.ready)
            begin
                scan_byte(text.text_byte, text.final_byte);
                void'(byte_q.pop_front());
                bytes_sent++;
            end
            if (!(text.valid && !text.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left   <= gap_left - 1;
                    text.valid <= 1'b0;
                end
                else if (byte_q.size() > 0)
                begin
                    text.valid      <= 1'b1;
                    text.text_byte  <= byte_q[0].b;
                    text.final_byte <= byte_q[0].f;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    text.valid <= 1'b0;
            end
        end
    end

    // token sink and checker
    always @(posedge clk or negedge rst_n)
    begin
        tok_t e;
        tok_t g;
        if (!rst_n)
            token.ready <= 1'b0;
        else
        begin
            token.ready <= (cycles[7:6] == 2'b00) || ($urandom_range(0, 3) != 0);
            if (token.valid && token.ready)
            begin
                tokens_seen++;
                g.token_kind       = token.token_kind;
                g.space_kind       = token.space_kind;
                g.code_point       = token.code_point;
                g.start_offset     = token.start_offset;
                g.byte_length      = token.byte_length;
                g.token_row        = token.token_row;
                g.start_column     = token.start_column;
                g.after_whitespace = token.after_whitespace;
                g.after_newline    = token.after_newline;
                g.run_end          = token.run_end;
                if (expected_tokens.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected token: %p", g);
                end
                else
                begin
                    e = expected_tokens.pop_front();
                    if (e.token_kind !== g.token_kind || e.space_kind !== g.space_kind
                        || e.code_point !== g.code_point || e.start_offset !== g.start_offset
                        || e.byte_length !== g.byte_length || e.token_row !== g.token_row
                        || e.start_column !== g.start_column
                        || e.after_whitespace !== g.after_whitespace
                        || e.after_newline !== g.after_newline || e.run_end !== g.run_end)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Token %0d mismatch\n  exp %p\n  got %p",
                                     tokens_seen, e, g);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

[filelist.f]
design/uts_pkg.sv
design/uts_if.sv
design/utf8_token_scanner.sv
tb/sv/tb_utf8_token_scanner.sv
